[hw/rtl/glrs_pkg.sv]
`default_nettype none

package glrs_pkg;

    localparam int COORD_W   = 32;
    localparam int ACC_W     = 40;
    localparam int LIMIT_W   = 12;
    localparam int RADIUS_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Squared distance, in whole pixels, below which the offsets are scaled up.
    localparam int NEAR_SQ    = 25;
    localparam int NEAR_SCALE = 10;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 12'd100;
    localparam logic [2*LIMIT_W-1:0] LIMIT_SQ_RESET = 24'd10000;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET   = 10'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_LENGTH  = 3'd0,
        CFG_NODE_RADIUS  = 3'd1,
        CFG_SCENE_LEFT   = 3'd2,
        CFG_SCENE_RIGHT  = 3'd3,
        CFG_SCENE_TOP    = 3'd4,
        CFG_SCENE_BOTTOM = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] self_x;
        logic signed [COORD_W-1:0] self_y;
        logic signed [COORD_W-1:0] other_x;
        logic signed [COORD_W-1:0] other_y;
        logic                      skip_other;
        logic                      hold_node;
        logic                      last_other;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] next_x;
        logic signed [COORD_W-1:0] next_y;
        logic                      moved;
    } out_t;

endpackage

`default_nettype wire

[hw/rtl/glrs_div.sv]
`default_nettype none

// Restoring divider of a fixed dividend (6 in fixed point) by an unsigned
// divisor, two quotient bits per cycle.
module glrs_div #(
    parameter int FRACTION_BITS = 16,
    parameter int DEN_W         = 37,
    parameter int QUO_W         = 2 * FRACTION_BITS + 3 + ((2 * FRACTION_BITS + 3) % 2)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [QUO_W-1:0]      quo
);

    localparam int DIVIDEND = 6;
    localparam int STEPS    = QUO_W / 2;
    localparam int CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [QUO_W-1:0] NUMER = QUO_W'(DIVIDEND) << (2 * FRACTION_BITS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] num_reg;
    logic [QUO_W-1:0] quo_reg;

    logic [DEN_W:0]   r1;
    logic [DEN_W:0]   r1s;
    logic [DEN_W:0]   r2;
    logic [DEN_W:0]   r2s;
    logic             ge1;
    logic             ge2;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
        r1  = {rem_reg, num_reg[QUO_W-1]};
        ge1 = (r1 >= {1'b0, den_reg});
        r1s = ge1 ? (r1 - {1'b0, den_reg}) : r1;
        r2  = {r1s[DEN_W-1:0], num_reg[QUO_W-2]};
        ge2 = (r2 >= {1'b0, den_reg});
        r2s = ge2 ? (r2 - {1'b0, den_reg}) : r2;
        rem_next = r2s[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                den_reg  <= den;
                rem_reg  <= '0;
                num_reg  <= NUMER;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                num_reg <= num_reg << 2;
                quo_reg <= {quo_reg[QUO_W-3:0], ge1, ge2};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/graph_layout_repulsion_step.sv]
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  glrs_pkg::in_t  (positions, skip/hold/last)
// m_        out        m_valid / m_ready  glrs_pkg::out_t (next position, moved)
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// An item with skip_other set goes straight to the finish state. Any other item takes the
// offsets, squares them and tests the squared distance against the repulsion range; one in
// range then runs the x and the y division on the shared divider. With last_other set the node
// is then placed in ST_PLACE1 to ST_PLACE4, or only in ST_PLACE4 with hold_node set.
// aresetn is synchronous and active low; it restores the register defaults.
// A result waiting on m_ready holds the block in its last placement cycle only.
module graph_layout_repulsion_step #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire glrs_pkg::in_t                    s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output glrs_pkg::out_t                        m_data,
    input  wire logic                             cfg_we,
    input  wire logic [glrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [glrs_pkg::CFG_W-1:0]       cfg_wdata
);

    import glrs_pkg::*;

    localparam int D_W    = COORD_W + 1;
    localparam int DQ_W   = D_W + 4;
    localparam int D2_W   = 2 * D_W;
    localparam int HI_W   = D2_W - 2 * FRACTION_BITS;
    localparam int CMP_W  = (HI_W > 2 * LIMIT_W) ? HI_W : 2 * LIMIT_W;
    localparam int QUO_W  = 2 * FRACTION_BITS + 3 + ((2 * FRACTION_BITS + 3) % 2);
    localparam int QX_W   = (QUO_W > ACC_W) ? QUO_W : ACC_W;
    localparam int PW     = (FRACTION_BITS + RADIUS_W + 2 > COORD_W + 2)
                            ? FRACTION_BITS + RADIUS_W + 2 : COORD_W + 2;
    // Velocity limit of 0.2, rounded to the nearest step.
    localparam logic signed [ACC_W-1:0] VLIM =
        ACC_W'(((2 ** FRACTION_BITS) * 2 + 5) / 10);
    localparam logic signed [ACC_W-1:0] NEG_VLIM = -VLIM;
    localparam logic signed [DQ_W-1:0]  SCALE_Q  = DQ_W'(NEAR_SCALE);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_MULX, ST_MULY, ST_SUM, ST_CMP,
        ST_DIVX_GO, ST_DIVX_WAIT, ST_DIVY_GO, ST_DIVY_WAIT,
        ST_FINISH, ST_PLACE1, ST_PLACE2, ST_PLACE3, ST_PLACE4
    } state_t;

    // Configuration.
    logic [2*LIMIT_W-1:0]       limit_sq_reg;
    logic [RADIUS_W-1:0]        radius_reg;
    logic signed [COORD_W-1:0]  left_reg;
    logic signed [COORD_W-1:0]  right_reg;
    logic signed [COORD_W-1:0]  top_reg;
    logic signed [COORD_W-1:0]  bottom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_sq_reg <= LIMIT_SQ_RESET;
            radius_reg   <= RADIUS_RESET;
            left_reg     <= '0;
            right_reg    <= '0;
            top_reg      <= '0;
            bottom_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_EDGE_LENGTH:  limit_sq_reg <= (2*LIMIT_W)'(cfg_wdata[LIMIT_W-1:0])
                                                * (2*LIMIT_W)'(cfg_wdata[LIMIT_W-1:0]);
                CFG_NODE_RADIUS:  radius_reg   <= cfg_wdata[RADIUS_W-1:0];
                CFG_SCENE_LEFT:   left_reg     <= cfg_wdata[COORD_W-1:0];
                CFG_SCENE_RIGHT:  right_reg    <= cfg_wdata[COORD_W-1:0];
                CFG_SCENE_TOP:    top_reg      <= cfg_wdata[COORD_W-1:0];
                CFG_SCENE_BOTTOM: bottom_reg   <= cfg_wdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Datapath registers.
    state_t                    state_reg;
    in_t                       in_reg;
    logic signed [D_W-1:0]     dx_reg;
    logic signed [D_W-1:0]     dy_reg;
    logic [D2_W-1:0]           prod_reg;
    logic [D2_W-1:0]           d2_reg;
    logic signed [DQ_W-1:0]    dqx_reg;
    logic signed [DQ_W-1:0]    dqy_reg;
    logic signed [ACC_W-1:0]   vx_reg;
    logic signed [ACC_W-1:0]   vy_reg;
    logic signed [PW-1:0]      px_reg;
    logic signed [PW-1:0]      py_reg;
    logic signed [PW-1:0]      lox_reg;
    logic signed [PW-1:0]      hix_reg;
    logic signed [PW-1:0]      loy_reg;
    logic signed [PW-1:0]      hiy_reg;
    logic                      m_valid_reg;
    out_t                      m_data_reg;

    // Shared squarer.
    logic signed [D_W-1:0] mul_sel;
    logic [D_W-1:0]        mul_mag;
    logic [D2_W-1:0]       mul_prod;

    always_comb begin
        mul_sel  = (state_reg == ST_MULY) ? dy_reg : dx_reg;
        mul_mag  = mul_sel[D_W-1] ? D_W'(-mul_sel) : D_W'(mul_sel);
        mul_prod = mul_mag * mul_mag;
    end

    // Range tests on the whole-pixel part of the squared distance.
    logic [HI_W-1:0]        d2_hi;
    logic                   near;
    logic                   in_range;
    logic signed [DQ_W-1:0] dx_ext;
    logic signed [DQ_W-1:0] dy_ext;
    logic signed [DQ_W-1:0] dqx_next;
    logic signed [DQ_W-1:0] dqy_next;

    always_comb begin
        d2_hi    = d2_reg[D2_W-1:2*FRACTION_BITS];
        near     = CMP_W'(d2_hi) < CMP_W'(NEAR_SQ);
        in_range = CMP_W'(d2_hi) < CMP_W'(limit_sq_reg);
        dx_ext   = DQ_W'(dx_reg);
        dy_ext   = DQ_W'(dy_reg);
        dqx_next = near ? DQ_W'(dx_ext * SCALE_Q) : dx_ext;
        dqy_next = near ? DQ_W'(dy_ext * SCALE_Q) : dy_ext;
    end

    // Divider and accumulation of the quotient.
    logic                   div_y;
    logic signed [DQ_W-1:0] dq_sel;
    logic [DQ_W-1:0]        div_den;
    logic                   div_start;
    logic                   div_done;
    logic [QUO_W-1:0]       div_quo;
    logic [QX_W-1:0]        quo_ext;
    logic [ACC_W-1:0]       q_mag;
    logic signed [ACC_W-1:0] acc_sel;
    logic signed [ACC_W:0]  acc_sum;
    logic signed [ACC_W-1:0] acc_next;

    always_comb begin
        div_y     = (state_reg == ST_DIVY_GO) || (state_reg == ST_DIVY_WAIT);
        dq_sel    = div_y ? dqy_reg : dqx_reg;
        div_den   = dq_sel[DQ_W-1] ? DQ_W'(-dq_sel) : DQ_W'(dq_sel);
        div_start = (state_reg == ST_DIVX_GO) || (state_reg == ST_DIVY_GO);
        quo_ext   = QX_W'(div_quo);
        // A zero offset saturates to the positive limit regardless of sign.
        if ((dq_sel == '0) || (quo_ext > QX_W'(ACC_MAX))) begin
            q_mag = ACC_MAX;
        end else begin
            q_mag = ACC_W'(quo_ext);
        end
        acc_sel = div_y ? vy_reg : vx_reg;
        if (dq_sel[DQ_W-1]) begin
            acc_sum = (ACC_W + 1)'(acc_sel) + $signed({1'b0, q_mag});
        end else begin
            acc_sum = (ACC_W + 1)'(acc_sel) - $signed({1'b0, q_mag});
        end
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    glrs_div #(
        .FRACTION_BITS (FRACTION_BITS),
        .DEN_W         (DQ_W),
        .QUO_W         (QUO_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Placement arithmetic.
    logic signed [ACC_W-1:0] cvx;
    logic signed [ACC_W-1:0] cvy;
    logic signed [PW-1:0]    rad_q;
    logic signed [PW-1:0]    sx_ext;
    logic signed [PW-1:0]    sy_ext;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;

    always_comb begin
        if (vx_reg > VLIM) begin
            cvx = VLIM;
        end else if (vx_reg < NEG_VLIM) begin
            cvx = NEG_VLIM;
        end else begin
            cvx = vx_reg;
        end
        if (vy_reg > VLIM) begin
            cvy = VLIM;
        end else if (vy_reg < NEG_VLIM) begin
            cvy = NEG_VLIM;
        end else begin
            cvy = vy_reg;
        end
        rad_q  = $signed(PW'({radius_reg, {FRACTION_BITS{1'b0}}}));
        sx_ext = PW'(in_reg.self_x);
        sy_ext = PW'(in_reg.self_y);
        if (px_reg > PW'(COORD_MAX)) begin
            nx = COORD_MAX;
        end else if (px_reg < PW'(COORD_MIN)) begin
            nx = COORD_MIN;
        end else begin
            nx = px_reg[COORD_W-1:0];
        end
        if (py_reg > PW'(COORD_MAX)) begin
            ny = COORD_MAX;
        end else if (py_reg < PW'(COORD_MIN)) begin
            ny = COORD_MIN;
        end else begin
            ny = py_reg[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            vx_reg      <= '0;
            vy_reg      <= '0;
        end else begin
            // In the last placement cycle the emit below handles a taken result.
            if (m_valid_reg && m_ready && (state_reg != ST_PLACE4)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= s_data.skip_other ? ST_FINISH : ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    dx_reg    <= D_W'(in_reg.other_x) - D_W'(in_reg.self_x);
                    dy_reg    <= D_W'(in_reg.other_y) - D_W'(in_reg.self_y);
                    state_reg <= ST_MULX;
                end
                ST_MULX: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_MULY;
                end
                ST_MULY: begin
                    d2_reg    <= prod_reg;
                    prod_reg  <= mul_prod;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    d2_reg    <= d2_reg + prod_reg;
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    dqx_reg   <= dqx_next;
                    dqy_reg   <= dqy_next;
                    state_reg <= in_range ? ST_DIVX_GO : ST_FINISH;
                end
                ST_DIVX_GO: begin
                    state_reg <= ST_DIVX_WAIT;
                end
                ST_DIVX_WAIT: begin
                    if (div_done) begin
                        vx_reg    <= acc_next;
                        state_reg <= ST_DIVY_GO;
                    end
                end
                ST_DIVY_GO: begin
                    state_reg <= ST_DIVY_WAIT;
                end
                ST_DIVY_WAIT: begin
                    if (div_done) begin
                        vy_reg    <= acc_next;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!in_reg.last_other) begin
                        state_reg <= ST_IDLE;
                    end else if (in_reg.hold_node) begin
                        px_reg    <= sx_ext;
                        py_reg    <= sy_ext;
                        state_reg <= ST_PLACE4;
                    end else begin
                        state_reg <= ST_PLACE1;
                    end
                end
                ST_PLACE1: begin
                    px_reg    <= sx_ext + PW'(cvx);
                    py_reg    <= sy_ext + PW'(cvy);
                    lox_reg   <= PW'(left_reg) - rad_q;
                    hix_reg   <= PW'(right_reg) + rad_q;
                    loy_reg   <= PW'(top_reg) - rad_q;
                    hiy_reg   <= PW'(bottom_reg) + rad_q;
                    state_reg <= ST_PLACE2;
                end
                ST_PLACE2: begin
                    px_reg    <= (px_reg < lox_reg) ? lox_reg : px_reg;
                    py_reg    <= (py_reg < loy_reg) ? loy_reg : py_reg;
                    state_reg <= ST_PLACE3;
                end
                ST_PLACE3: begin
                    // The upper bound is applied last so it wins on crossed bounds.
                    px_reg    <= (px_reg > hix_reg) ? hix_reg : px_reg;
                    py_reg    <= (py_reg > hiy_reg) ? hiy_reg : py_reg;
                    state_reg <= ST_PLACE4;
                end
                ST_PLACE4: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.next_x <= nx;
                        m_data_reg.next_y <= ny;
                        m_data_reg.moved  <= (nx != in_reg.self_x) || (ny != in_reg.self_y);
                        m_valid_reg       <= 1'b1;
                        vx_reg            <= '0;
                        vy_reg            <= '0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[hw/rtl/glrs_check.sv]
`default_nettype none

module glrs_check (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire glrs_pkg::in_t  s_data,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire glrs_pkg::out_t m_data
);

    import glrs_pkg::*;

    // The block comes out of reset idle and with no result pending.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("block not idle after reset");

    // Every accepted item leaves the block busy, so the input is not ready right after acceptance.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready right after an item was accepted");

    // A new result only appears at the end of work on an item.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the block was idle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

endmodule

bind graph_layout_repulsion_step glrs_check u_glrs_check (.*);

`default_nettype wire
